/* rtl/vgpc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vgpc_pkg
// Shared widths, register indexes and codes of the voxel grid point counter.
// ----------------------------------------------------------------------------
package vgpc_pkg;

    localparam int COORD_W    = 32;
    localparam int QIDX_W     = 5;
    localparam int DIM_W      = 6;
    localparam int THR_W      = 16;
    localparam int OUT_CNT_W  = 16;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 112;
    localparam int M_TDATA_W  = 40;
    localparam int AXIS_LAT   = 4;

    typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

    localparam cfg_addr_t REG_INV_RES   = 4'd0;
    localparam cfg_addr_t REG_ORIGIN_X  = 4'd1;
    localparam cfg_addr_t REG_ORIGIN_Y  = 4'd2;
    localparam cfg_addr_t REG_ORIGIN_Z  = 4'd3;
    localparam cfg_addr_t REG_GRID_LEN  = 4'd4;
    localparam cfg_addr_t REG_GRID_WID  = 4'd5;
    localparam cfg_addr_t REG_GRID_HGT  = 4'd6;
    localparam cfg_addr_t REG_THRESHOLD = 4'd7;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

endpackage
`default_nettype wire

/* rtl/voxel_grid_point_counter.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_grid_point_counter
// Quantizes points into a voxel grid and keeps a saturating count per voxel.
// ----------------------------------------------------------------------------
// One item is in flight at a time. An insert passes from one accepted beat to
// the next through the per-axis index lanes (offset, partial products, sum,
// bound check), then address, count memory read, update and result load. A
// query skips the lanes. A result that is not taken holds the block in its
// result load until the output register frees. After reset the count memory
// is swept to zero, one entry a cycle, all AXIS_MAX^3 entries (32768 at the
// default size); s_tready stays low during the sweep, configuration writes
// are taken throughout.
module voxel_grid_point_counter
    import vgpc_pkg::*;
#(
    parameter int AXIS_MAX    = 32,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // point_x[31:0], point_y[63:32], point_z[95:64],
    // query_x[100:96], query_y[105:101], query_z[110:106], zero pad
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // cmd
    input  wire logic                  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // voxel_x[4:0], voxel_y[9:5], voxel_z[14:10], point_count[30:15],
    // used[31], out_of_range[32], zero pad
    output logic      [M_TDATA_W-1:0]  m_tdata
);

    localparam int IDX_W  = $clog2(AXIS_MAX);
    localparam int DEPTH  = AXIS_MAX * AXIS_MAX * AXIS_MAX;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LAT_W  = $clog2(AXIS_LAT);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_CALC, S_ADDR, S_READ, S_UPDATE, S_SEND
    } state_t;

    // configuration
    logic [COORD_W-1:0] inv_res_reg, org_x_reg, org_y_reg, org_z_reg;
    logic [DIM_W-1:0]   grid_len_reg, grid_wid_reg, grid_hgt_reg;
    logic [THR_W-1:0]   thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_res_reg  <= COORD_W'(65536);
            org_x_reg    <= '0;
            org_y_reg    <= '0;
            org_z_reg    <= '0;
            grid_len_reg <= DIM_W'(32);
            grid_wid_reg <= DIM_W'(32);
            grid_hgt_reg <= DIM_W'(32);
            thr_reg      <= THR_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_INV_RES:   inv_res_reg  <= cfg_wdata[COORD_W-1:0];
                REG_ORIGIN_X:  org_x_reg    <= cfg_wdata[COORD_W-1:0];
                REG_ORIGIN_Y:  org_y_reg    <= cfg_wdata[COORD_W-1:0];
                REG_ORIGIN_Z:  org_z_reg    <= cfg_wdata[COORD_W-1:0];
                REG_GRID_LEN:  grid_len_reg <= cfg_wdata[DIM_W-1:0];
                REG_GRID_WID:  grid_wid_reg <= cfg_wdata[DIM_W-1:0];
                REG_GRID_HGT:  grid_hgt_reg <= cfg_wdata[DIM_W-1:0];
                REG_THRESHOLD: thr_reg      <= cfg_wdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // control and payload registers
    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [LAT_W-1:0]     calc_cnt_reg, calc_cnt_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                 cmd_reg, cmd_next;
    logic [COORD_W-1:0]   pt_x_reg, pt_x_next, pt_y_reg, pt_y_next, pt_z_reg, pt_z_next;
    logic [QIDX_W-1:0]    q_x_reg, q_x_next, q_y_reg, q_y_next, q_z_reg, q_z_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [QIDX_W-1:0]    res_x_reg, res_x_next, res_y_reg, res_y_next;
    logic [QIDX_W-1:0]    res_z_reg, res_z_next;
    logic                 res_oor_reg, res_oor_next;
    logic [COUNT_WIDTH-1:0] res_cnt_reg, res_cnt_next;

    // index lanes
    logic [IDX_W-1:0] idx_x, idx_y, idx_z;
    logic             ok_x, ok_y, ok_z;

    vgpc_axis #(.AXIS_MAX(AXIS_MAX)) u_axis_x (
        .aclk(aclk), .point(pt_x_reg), .origin(org_x_reg), .inv_res(inv_res_reg),
        .dim(grid_len_reg), .idx(idx_x), .ok(ok_x)
    );
    vgpc_axis #(.AXIS_MAX(AXIS_MAX)) u_axis_y (
        .aclk(aclk), .point(pt_y_reg), .origin(org_y_reg), .inv_res(inv_res_reg),
        .dim(grid_wid_reg), .idx(idx_y), .ok(ok_y)
    );
    vgpc_axis #(.AXIS_MAX(AXIS_MAX)) u_axis_z (
        .aclk(aclk), .point(pt_z_reg), .origin(org_z_reg), .inv_res(inv_res_reg),
        .dim(grid_hgt_reg), .idx(idx_z), .ok(ok_z)
    );

    // count memory
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [COUNT_WIDTH-1:0] ram_wdata;
    logic [COUNT_WIDTH-1:0] ram_rdata;

    vgpc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(DEPTH)) u_ram (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(addr_reg), .rdata(ram_rdata)
    );

    logic                   is_insert;
    logic [IDX_W-1:0]       ax, ay, az;
    logic                   q_oor, ins_ok;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic                   res_used;

    assign is_insert = (cmd_reg == CMD_INSERT);
    assign ins_ok    = ok_x && ok_y && ok_z;
    assign q_oor     = !(({1'b0, q_x_reg} < grid_len_reg) && (32'(q_x_reg) < 32'(AXIS_MAX)) &&
                         ({1'b0, q_y_reg} < grid_wid_reg) && (32'(q_y_reg) < 32'(AXIS_MAX)) &&
                         ({1'b0, q_z_reg} < grid_hgt_reg) && (32'(q_z_reg) < 32'(AXIS_MAX)));
    assign ax        = is_insert ? idx_x : IDX_W'(q_x_reg);
    assign ay        = is_insert ? idx_y : IDX_W'(q_y_reg);
    assign az        = is_insert ? idx_z : IDX_W'(q_z_reg);
    assign cnt_inc   = (ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + 1'b1;
    assign res_used  = !res_oor_reg && (32'(res_cnt_reg) >= 32'(thr_reg));

    assign ram_we    = (state_reg == S_CLEAR) ||
                       ((state_reg == S_UPDATE) && is_insert && !res_oor_reg);
    assign ram_waddr = (state_reg == S_CLEAR) ? clr_cnt_reg : addr_reg;
    assign ram_wdata = (state_reg == S_CLEAR) ? '0 : cnt_inc;

    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        calc_cnt_next = calc_cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        cmd_next      = cmd_reg;
        pt_x_next     = pt_x_reg;
        pt_y_next     = pt_y_reg;
        pt_z_next     = pt_z_reg;
        q_x_next      = q_x_reg;
        q_y_next      = q_y_reg;
        q_z_next      = q_z_reg;
        addr_next     = addr_reg;
        res_x_next    = res_x_reg;
        res_y_next    = res_y_reg;
        res_z_next    = res_z_reg;
        res_oor_next  = res_oor_reg;
        res_cnt_next  = res_cnt_reg;
        unique case (state_reg)
            S_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next      = s_tuser;
                    pt_x_next     = s_tdata[31:0];
                    pt_y_next     = s_tdata[63:32];
                    pt_z_next     = s_tdata[95:64];
                    q_x_next      = s_tdata[100:96];
                    q_y_next      = s_tdata[105:101];
                    q_z_next      = s_tdata[110:106];
                    calc_cnt_next = '0;
                    state_next    = (s_tuser == CMD_INSERT) ? S_CALC : S_ADDR;
                end
            end
            S_CALC: begin
                calc_cnt_next = calc_cnt_reg + 1'b1;
                if (calc_cnt_reg == LAT_W'(AXIS_LAT - 1)) begin
                    state_next = S_ADDR;
                end
            end
            S_ADDR: begin
                addr_next = ADDR_W'((32'(ax) * AXIS_MAX + 32'(ay)) * AXIS_MAX + 32'(az));
                if (is_insert) begin
                    res_oor_next = !ins_ok;
                    res_x_next   = ins_ok ? QIDX_W'(idx_x) : '0;
                    res_y_next   = ins_ok ? QIDX_W'(idx_y) : '0;
                    res_z_next   = ins_ok ? QIDX_W'(idx_z) : '0;
                end else begin
                    res_oor_next = q_oor;
                    res_x_next   = q_x_reg;
                    res_y_next   = q_y_reg;
                    res_z_next   = q_z_reg;
                end
                state_next = S_READ;
            end
            S_READ: begin
                state_next = S_UPDATE;
            end
            S_UPDATE: begin
                if (res_oor_reg) begin
                    res_cnt_next = '0;
                end else if (is_insert) begin
                    res_cnt_next = cnt_inc;
                end else begin
                    res_cnt_next = ram_rdata;
                end
                state_next = S_SEND;
            end
            S_SEND: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'b0, res_oor_reg, res_used, OUT_CNT_W'(res_cnt_reg),
                                     res_z_reg, res_y_reg, res_x_reg};
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            calc_cnt_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            calc_cnt_reg <= calc_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
        cmd_reg     <= cmd_next;
        pt_x_reg    <= pt_x_next;
        pt_y_reg    <= pt_y_next;
        pt_z_reg    <= pt_z_next;
        q_x_reg     <= q_x_next;
        q_y_reg     <= q_y_next;
        q_z_reg     <= q_z_next;
        addr_reg    <= addr_next;
        res_x_reg   <= res_x_next;
        res_y_reg   <= res_y_next;
        res_z_reg   <= res_z_next;
        res_oor_reg <= res_oor_next;
        res_cnt_reg <= res_cnt_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // a count is written back only for an insert that landed in the grid
    a_write_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && state_reg != S_CLEAR) |-> (is_insert && !res_oor_reg))
        else $error("count write for query or out-of-range item");

    // a new result beat only comes out of the result load
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_next && !m_tvalid_reg) |-> (state_reg == S_SEND))
        else $error("result beat raised outside result load");

    // out-of-range beats carry no count and no used flag
    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tdata_reg[32]) |-> (m_tdata_reg[31:15] == '0))
        else $error("out-of-range beat with nonzero count");

    // the sweep leaves the memory only after the last entry
    a_clear_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && $past(state_reg) == S_CLEAR) |->
        ($past(clr_cnt_reg) == ADDR_W'(DEPTH - 1)))
        else $error("clear sweep ended early");

endmodule
`default_nettype wire

/* rtl/vgpc_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vgpc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module vgpc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

/* rtl/vgpc_axis.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vgpc_axis
// Four-stage index lane for one axis: offset, partial products, sum, bound.
// ----------------------------------------------------------------------------
module vgpc_axis
    import vgpc_pkg::*;
#(
    parameter int AXIS_MAX = 32,
    localparam int IDX_W   = $clog2(AXIS_MAX)
) (
    input  wire logic               aclk,
    input  wire logic [COORD_W-1:0] point,
    input  wire logic [COORD_W-1:0] origin,
    input  wire logic [COORD_W-1:0] inv_res,
    input  wire logic [DIM_W-1:0]   dim,
    output logic      [IDX_W-1:0]   idx,
    output logic                    ok
);

    localparam int H = COORD_W / 2;

    logic [COORD_W:0]     diff;
    logic [COORD_W:0]     diff_neg;
    logic [2*COORD_W-1:0] prod;
    logic                 in_grid;

    logic [COORD_W-1:0]   s1_mag_reg;
    logic                 s1_neg_reg;
    logic                 s1_zero_reg;
    logic [2*H-1:0]       s2_ll_reg, s2_lh_reg, s2_hl_reg, s2_hh_reg;
    logic                 s2_neg_reg, s2_zero_reg;
    logic [COORD_W-1:0]   s3_ip_reg;
    logic                 s3_neg_reg, s3_zero_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic                 ok_reg;

    assign diff     = {point[COORD_W-1], point} - {origin[COORD_W-1], origin};
    assign diff_neg = -diff;
    assign prod     = {s2_hh_reg, s2_ll_reg}
                    + {{H{1'b0}}, s2_lh_reg, {H{1'b0}}}
                    + {{H{1'b0}}, s2_hl_reg, {H{1'b0}}};
    assign in_grid  = (s3_ip_reg < COORD_W'(dim)) && (s3_ip_reg < COORD_W'(AXIS_MAX));

    always_ff @(posedge aclk) begin
        // offset and magnitude
        s1_neg_reg  <= diff[COORD_W];
        s1_mag_reg  <= diff[COORD_W] ? diff_neg[COORD_W-1:0] : diff[COORD_W-1:0];
        s1_zero_reg <= (diff == '0) || (inv_res == '0);
        // partial products
        s2_ll_reg   <= s1_mag_reg[H-1:0]       * inv_res[H-1:0];
        s2_lh_reg   <= s1_mag_reg[H-1:0]       * inv_res[COORD_W-1:H];
        s2_hl_reg   <= s1_mag_reg[COORD_W-1:H] * inv_res[H-1:0];
        s2_hh_reg   <= s1_mag_reg[COORD_W-1:H] * inv_res[COORD_W-1:H];
        s2_neg_reg  <= s1_neg_reg;
        s2_zero_reg <= s1_zero_reg;
        // integer part of the product
        s3_ip_reg   <= prod[2*COORD_W-1:COORD_W];
        s3_neg_reg  <= s2_neg_reg;
        s3_zero_reg <= s2_zero_reg;
        // bound check
        idx_reg     <= s3_ip_reg[IDX_W-1:0];
        ok_reg      <= !(s3_neg_reg && !s3_zero_reg) && in_grid;
    end

    assign idx = idx_reg;
    assign ok  = ok_reg;

endmodule
`default_nettype wire
